/* sv/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and codes of the regula falsi root finder.
// ----------------------------------------------------------------------------
package rfr_pkg;

    typedef logic [63:0] t_word;

    localparam t_word SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam t_word MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_TOL    = 2'd1;
    localparam logic [1:0] CFG_MAXIT  = 2'd2;

    typedef enum logic [1:0] {
        ST_EVAL, ST_ROOT, ST_NONMONO, ST_NOCONV
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE, PH_LOW, PH_HIGH, PH_TRIAL
    } t_phase;

    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_SET_LOW, OP_SET_HIGH, OP_BEGIN, OP_FP_SETUP,
        OP_MUL, OP_DIVF, OP_FP_DONE, OP_SET_TRIAL, OP_RELAX,
        OP_UPDATE, OP_MONO, OP_JUDGE, OP_MID, OP_COMMIT
    } t_op;

    typedef enum logic [2:0] {
        PT_ZERO, PT_LOW, PT_HIGH, PT_TRIAL, PT_NEXT
    } t_pt_sel;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_BEGIN, S_MUL, S_DIV, S_DIVW, S_FPDONE,
        S_RELAX, S_TOL, S_MONO, S_CHECK, S_JUDGE, S_DECIDE, S_EMIT
    } t_state;

    typedef struct packed {
        t_op     op;
        logic    load;
        logic    emit;
        t_status status;
        t_pt_sel pt_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_bit;
        logic low_known;
        logic high_known;
        logic den_zero;
        logic mul_done;
        logic div_busy;
        logic in_tol;
        logic iter_max;
        logic both_seen;
        logic bisect;
    } t_dp_stat;

endpackage

/* sv/rfr_div.sv */
// ----------------------------------------------------------------------------
// rfr_div
// Restoring 128/64 divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module rfr_div
    import rfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_hi,
    input  t_word i_lo,
    input  t_word i_den,
    output logic  o_busy,
    output t_word o_quot
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    t_word       r_rem, r_lo, r_q, r_d;
    logic        w_carry, w_take;
    t_word       w_sh;

    assign w_carry = r_rem[63];
    assign w_sh    = {r_rem[62:0], r_lo[63]};
    assign w_take  = w_carry || (w_sh >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_hi < i_den);
            r_cnt  <= 6'd63;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_hi;
            r_lo  <= i_lo;
            r_d   <= i_den;
            r_q   <= (i_hi >= i_den) ? ALL_ONES : '0;
        end else if (r_busy) begin
            r_rem <= w_take ? (w_sh - r_d) : w_sh;
            r_lo  <= {r_lo[62:0], 1'b0};
            r_q   <= {r_q[62:0], w_take};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

/* sv/rfr_datapath.sv */
// ----------------------------------------------------------------------------
// rfr_datapath
// Bracket state, configuration, false position arithmetic and result register.
// ----------------------------------------------------------------------------
module rfr_datapath
    import rfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  t_word       i_cfg_data,
    input  logic        i_command,
    input  t_word       i_x_low,
    input  t_word       i_x_high,
    input  t_word       i_known_low_value,
    input  t_word       i_known_high_value,
    input  logic        i_low_known,
    input  logic        i_high_known,
    input  t_word       i_f_value,
    output logic [1:0]  o_status,
    output t_word       o_point_x,
    output logic [15:0] o_steps_done
);

    function automatic logic slt(t_word a, t_word b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic t_word adiff(t_word a, t_word b);
        return slt(a, b) ? (b - a) : (a - b);
    endfunction

    // configuration
    t_word       r_target;
    logic [62:0] r_tol;
    logic [15:0] r_maxit;

    // latched transaction
    logic  r_cmd_bit, r_kl, r_kh;
    t_word r_xl, r_xh, r_vl, r_vh, r_f;

    // solver state
    t_word       r_lp, r_lr, r_hp, r_hr, r_tp, r_wt, r_pw, r_ptr;
    logic        r_rise, r_fall, r_bis;
    logic [15:0] r_iter, n_iter;

    // arithmetic
    t_word        r_num, r_den, r_span, r_next, r_window;
    logic         r_neg;
    logic [127:0] r_prod, w_pp_ext;
    logic [63:0]  r_pp, w_pp;
    logic [1:0]   r_pp_sh;
    logic [2:0]   r_mcnt;
    logic [31:0]  w_ma, w_mb;

    logic         w_swap, w_lk, w_hk, w_div_start, w_div_busy;
    t_word        w_div_hi, w_div_lo, w_div_den, w_quot, w_resid, w_xb, w_moved;
    t_word        w_ma64, w_mb64, w_mid, w_fres;
    logic [68:0]  w_w20, w_p19;
    logic [66:0]  w_r5;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_tol    <= 63'd4295;
            r_maxit  <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_TOL:    r_tol    <= i_cfg_data[62:0];
                CFG_MAXIT:  r_maxit  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_bit <= i_command;
            r_xl <= i_x_low;
            r_xh <= i_x_high;
            r_vl <= i_known_low_value;
            r_vh <= i_known_high_value;
            r_kl <= i_low_known;
            r_kh <= i_high_known;
            r_f  <= i_f_value;
        end
    end

    assign w_swap = slt(r_xh, r_xl);
    assign w_lk   = w_swap ? r_kh : r_kl;
    assign w_hk   = w_swap ? r_kl : r_kh;

    // 32x32 partial products, registered before accumulation
    assign w_ma = r_mcnt[1] ? r_num[63:32] : r_num[31:0];
    assign w_mb = r_mcnt[0] ? r_span[63:32] : r_span[31:0];
    assign w_ma64 = {32'd0, w_ma};
    assign w_mb64 = {32'd0, w_mb};
    assign w_pp = w_ma64 * w_mb64;

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_ext = {64'd0, r_pp};
            2'd1:    w_pp_ext = {32'd0, r_pp, 32'd0};
            default: w_pp_ext = {r_pp, 64'd0};
        endcase
    end

    assign w_resid     = adiff(r_ptr, r_wt);
    assign w_fres      = adiff(r_f, r_wt);
    // |r| > floor(|p| / 5) holds exactly when 5 * |r| > |p|
    assign w_r5        = ({3'd0, w_fres} << 2) + {3'd0, w_fres};
    assign w_div_start = (i_cmd.op == OP_DIVF);
    assign w_div_hi    = r_prod[127:64];
    assign w_div_lo    = r_prod[63:0];
    assign w_div_den   = r_den;

    rfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_hi    (w_div_hi),
        .i_lo    (w_div_lo),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Saturating move of low_point by the quotient
    always_comb begin
        w_xb = r_lp ^ SIGN_BIT;
        if (r_neg) begin
            w_moved = ((w_quot > w_xb) ? '0 : (w_xb - w_quot)) ^ SIGN_BIT;
        end else begin
            w_moved = ((w_quot > ~w_xb) ? ALL_ONES : (w_xb + w_quot)) ^ SIGN_BIT;
        end
    end

    always_comb begin
        t_word a, b;
        a = r_lp ^ SIGN_BIT;
        b = r_hp ^ SIGN_BIT;
        w_mid = ((a >> 1) + (b >> 1) + {63'd0, a[0] & b[0]}) ^ SIGN_BIT;
    end

    assign w_w20 = ({5'd0, r_window} << 4) + ({5'd0, r_window} << 2);
    assign w_p19 = ({5'd0, r_pw} << 4) + ({5'd0, r_pw} << 1) + {5'd0, r_pw};

    always_comb begin
        case (i_cmd.op)
            OP_START:  n_iter = '0;
            OP_COMMIT: n_iter = r_iter + 16'd1;
            default:   n_iter = r_iter;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0; r_lr <= '0; r_hp <= '0; r_hr <= '0; r_tp <= '0; r_wt <= '0;
            r_pw <= ALL_ONES;
            r_ptr <= MAX_POS;
            r_rise <= 1'b0; r_fall <= 1'b0; r_bis <= 1'b0;
            r_iter <= '0;
        end else begin
            r_iter <= n_iter;
            case (i_cmd.op)
                OP_START: begin
                    r_lp  <= w_swap ? r_xh : r_xl;
                    r_hp  <= w_swap ? r_xl : r_xh;
                    r_lr  <= w_lk ? (w_swap ? r_vh : r_vl) : '0;
                    r_hr  <= w_hk ? (w_swap ? r_vl : r_vh) : '0;
                    r_wt  <= r_target;
                    r_pw  <= ALL_ONES;
                    r_ptr <= MAX_POS;
                    r_rise <= 1'b0; r_fall <= 1'b0; r_bis <= 1'b0;
                    r_tp  <= '0;
                end
                OP_SET_LOW:  r_lr <= r_f;
                OP_SET_HIGH: r_hr <= r_f;
                OP_BEGIN: begin
                    r_rise <= slt(r_lr, r_hr);
                    r_fall <= slt(r_hr, r_lr);
                end
                OP_SET_TRIAL: r_tp <= r_next;
                OP_RELAX: begin
                    if (r_iter != 16'd0 && slt(r_lp, r_tp) && slt(r_tp, r_hp)
                        && adiff(r_hp, r_lp) < {1'b0, r_tol}) begin
                        r_wt <= r_f;
                    end
                end
                OP_UPDATE: begin
                    if (slt(r_tp, r_lp)) begin
                        r_hp <= r_lp; r_hr <= r_lr;
                        r_lp <= r_tp; r_lr <= r_f;
                    end else if (slt(r_hp, r_tp)) begin
                        r_lp <= r_hp; r_lr <= r_hr;
                        r_hp <= r_tp; r_hr <= r_f;
                    end else if (r_f != r_wt && r_hr != r_wt) begin
                        if (slt(r_f, r_wt) == slt(r_hr, r_wt)) begin
                            r_hp <= r_tp; r_hr <= r_f;
                        end else begin
                            r_lp <= r_tp; r_lr <= r_f;
                        end
                    end
                end
                OP_MONO: begin
                    r_rise <= r_rise || slt(r_lr, r_hr);
                    r_fall <= r_fall || slt(r_hr, r_lr);
                end
                OP_JUDGE: begin
                    if (w_r5 > {3'd0, w_resid} && w_w20 > w_p19) begin
                        r_bis <= 1'b1;
                    end
                    r_ptr <= r_f;
                end
                OP_COMMIT: begin
                    r_pw <= r_window;
                    r_tp <= r_next;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_BEGIN || i_cmd.op == OP_FP_SETUP) begin
            r_num   <= adiff(r_lr, r_wt);
            r_den   <= adiff(r_lr, r_hr);
            r_span  <= adiff(r_hp, r_lp);
            r_neg   <= slt(r_lr, r_wt) != slt(r_lr, r_hr);
            r_prod  <= '0;
            r_pp    <= '0;
            r_pp_sh <= '0;
            r_mcnt  <= '0;
        end else if (i_cmd.op == OP_MUL) begin
            r_pp    <= w_pp;
            r_pp_sh <= {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};
            r_prod  <= r_prod + w_pp_ext;
            r_mcnt  <= r_mcnt + 3'd1;
        end
        if (i_cmd.op == OP_FP_DONE) begin
            r_next <= w_moved;
        end else if (i_cmd.op == OP_MID) begin
            r_next <= w_mid;
        end
        if (i_cmd.op == OP_MONO) begin
            r_window <= adiff(r_hp, r_lp);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status     <= i_cmd.status;
            o_steps_done <= n_iter;
            case (i_cmd.pt_sel)
                PT_LOW:   o_point_x <= r_lp;
                PT_HIGH:  o_point_x <= r_hp;
                PT_TRIAL: o_point_x <= r_tp;
                PT_NEXT:  o_point_x <= r_next;
                default:  o_point_x <= '0;
            endcase
        end
    end

    assign o_stat.cmd_bit    = r_cmd_bit;
    assign o_stat.low_known  = w_lk;
    assign o_stat.high_known = w_hk;
    assign o_stat.den_zero   = (r_lr == r_hr);
    assign o_stat.mul_done   = (r_mcnt == 3'd4);
    assign o_stat.div_busy   = w_div_busy;
    assign o_stat.in_tol     = w_fres <= {1'b0, r_tol};
    assign o_stat.iter_max   = r_iter >= r_maxit;
    assign o_stat.both_seen  = r_rise && r_fall;
    assign o_stat.bisect     = r_bis;

endmodule

/* sv/rfr_ctrl.sv */
// ----------------------------------------------------------------------------
// rfr_ctrl
// Sequencer: solve phase, datapath commands and output handshake.
// ----------------------------------------------------------------------------
module rfr_ctrl
    import rfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_phase  r_phase, n_phase, r_em_phase, n_em_phase;
    logic    r_pending, n_pending, r_loop, n_loop, r_out_valid;
    t_status r_em_status, n_em_status;
    t_pt_sel r_em_sel, n_em_sel;
    t_op     r_em_op, n_em_op;
    logic    w_can_emit;

    assign w_can_emit = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_loop      = r_loop;
        n_em_status = r_em_status;
        n_em_sel    = r_em_sel;
        n_em_op     = r_em_op;
        n_em_phase  = r_em_phase;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                n_state = S_EMIT;
                n_em_status = ST_EVAL;
                n_em_op = OP_NONE;
                if (!i_stat.cmd_bit) begin
                    n_pending = !i_stat.high_known;
                    if (!i_stat.low_known) begin
                        n_em_sel = PT_LOW; n_em_phase = PH_LOW;
                    end else if (!i_stat.high_known) begin
                        n_em_sel = PT_HIGH; n_em_phase = PH_HIGH;
                    end else begin
                        n_state = S_BEGIN;
                    end
                end else begin
                    case (r_phase)
                        PH_LOW: begin
                            if (r_pending) begin
                                n_em_sel = PT_HIGH; n_em_phase = PH_HIGH;
                            end else begin
                                n_state = S_BEGIN;
                            end
                        end
                        PH_HIGH: begin
                            n_pending = 1'b0;
                            n_state = S_BEGIN;
                        end
                        PH_TRIAL: n_state = S_RELAX;
                        default: begin
                            n_em_status = ST_NOCONV; n_em_sel = PT_ZERO;
                            n_em_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            S_BEGIN: begin
                n_loop = 1'b0;
                if (i_stat.den_zero) begin
                    n_state = S_EMIT; n_em_status = ST_NOCONV; n_em_sel = PT_ZERO;
                    n_em_op = OP_NONE; n_em_phase = PH_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  if (i_stat.mul_done) n_state = S_DIV;
            S_DIV:  n_state = S_DIVW;
            S_DIVW: if (!i_stat.div_busy) n_state = S_FPDONE;
            S_FPDONE: begin
                n_state = S_EMIT; n_em_status = ST_EVAL; n_em_sel = PT_NEXT;
                n_em_op = r_loop ? OP_COMMIT : OP_SET_TRIAL; n_em_phase = PH_TRIAL;
            end
            S_RELAX: n_state = S_TOL;
            S_TOL: begin
                if (i_stat.in_tol) begin
                    n_state = S_EMIT; n_em_status = ST_ROOT; n_em_sel = PT_TRIAL;
                    n_em_op = OP_NONE; n_em_phase = PH_IDLE;
                end else if (i_stat.iter_max) begin
                    n_state = S_EMIT; n_em_status = ST_NOCONV; n_em_sel = PT_ZERO;
                    n_em_op = OP_NONE; n_em_phase = PH_IDLE;
                end else begin
                    n_state = S_MONO;
                end
            end
            S_MONO: n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.both_seen) begin
                    n_state = S_EMIT; n_em_status = ST_NONMONO; n_em_sel = PT_ZERO;
                    n_em_op = OP_NONE; n_em_phase = PH_IDLE;
                end else begin
                    n_state = S_JUDGE;
                end
            end
            S_JUDGE: n_state = S_DECIDE;
            S_DECIDE: begin
                n_loop = 1'b1;
                if (i_stat.bisect) begin
                    n_state = S_EMIT; n_em_status = ST_EVAL; n_em_sel = PT_NEXT;
                    n_em_op = OP_COMMIT; n_em_phase = PH_TRIAL;
                end else if (i_stat.den_zero) begin
                    n_state = S_EMIT; n_em_status = ST_NOCONV; n_em_sel = PT_ZERO;
                    n_em_op = OP_NONE; n_em_phase = PH_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    n_state = S_IDLE;
                    n_phase = r_em_phase;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, load: 1'b0, emit: 1'b0, status: r_em_status,
                  pt_sel: r_em_sel};
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_DECODE: begin
                if (!i_stat.cmd_bit) begin
                    o_cmd.op = OP_START;
                end else if (r_phase == PH_LOW) begin
                    o_cmd.op = OP_SET_LOW;
                end else if (r_phase == PH_HIGH) begin
                    o_cmd.op = OP_SET_HIGH;
                end
            end
            S_BEGIN:  o_cmd.op = OP_BEGIN;
            S_MUL:    o_cmd.op = OP_MUL;
            S_DIV:    o_cmd.op = OP_DIVF;
            S_FPDONE: o_cmd.op = OP_FP_DONE;
            S_RELAX:  o_cmd.op = OP_RELAX;
            S_TOL:    if (!i_stat.in_tol && !i_stat.iter_max) o_cmd.op = OP_UPDATE;
            S_MONO:   o_cmd.op = OP_MONO;
            S_JUDGE:  o_cmd.op = OP_JUDGE;
            S_DECIDE: begin
                if (i_stat.bisect) begin
                    o_cmd.op = OP_MID;
                end else if (!i_stat.den_zero) begin
                    o_cmd.op = OP_FP_SETUP;
                end
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    o_cmd.op   = r_em_op;
                    o_cmd.emit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_pending   <= 1'b0;
            r_loop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_em_status <= ST_EVAL;
            r_em_sel    <= PT_ZERO;
            r_em_op     <= OP_NONE;
            r_em_phase  <= PH_IDLE;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_loop      <= n_loop;
            r_em_status <= n_em_status;
            r_em_sel    <= n_em_sel;
            r_em_op     <= n_em_op;
            r_em_phase  <= n_em_phase;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/regula_falsi_root_finder.sv */
// ----------------------------------------------------------------------------
// regula_falsi_root_finder
// False position root search with bisection fallback, signed Q32.32.
// ----------------------------------------------------------------------------
// One transaction in, one result out. A start or end-value transaction that
// asks for a bracket end answers without arithmetic; one that runs a false
// position step uses the bit-serial divider and a 64x64 multiply built from
// 32x32 partial products. A loop step adds the bracket update and checks, and
// in bisection mode takes the bracket midpoint instead of the divide. A new
// transaction is taken once the result is registered.
module regula_falsi_root_finder
    import rfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [63:0] i_x_low,
    input  logic [63:0] i_x_high,
    input  logic [63:0] i_known_low_value,
    input  logic [63:0] i_known_high_value,
    input  logic        i_low_known,
    input  logic        i_high_known,
    input  logic [63:0] i_f_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_point_x,
    output logic [15:0] o_steps_done
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rfr_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_command          (i_command),
        .i_x_low            (i_x_low),
        .i_x_high           (i_x_high),
        .i_known_low_value  (i_known_low_value),
        .i_known_high_value (i_known_high_value),
        .i_low_known        (i_low_known),
        .i_high_known       (i_high_known),
        .i_f_value          (i_f_value),
        .o_status           (o_status),
        .o_point_x          (o_point_x),
        .o_steps_done       (o_steps_done)
    );

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NONMONO || o_status == ST_NOCONV)
        |-> o_point_x == 64'd0)
        else $error("failure result carries nonzero point");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while transaction in progress");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

endmodule

/* tb/tb_regula_falsi_root_finder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regula_falsi_root_finder
// Self-checking bench: solve sequences against a behavioral root-finder model.
// ----------------------------------------------------------------------------
module tb_regula_falsi_root_finder
    import rfr_pkg::*;
();

    typedef struct {
        logic        command;
        logic [63:0] x_low;
        logic [63:0] x_high;
        logic [63:0] kv_low;
        logic [63:0] kv_high;
        logic        low_known;
        logic        high_known;
        logic [63:0] f_value;
    } t_req;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] point_x;
        logic [15:0] steps;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b0;
    logic [63:0] i_x_low = '0, i_x_high = '0, i_known_low_value = '0;
    logic [63:0] i_known_high_value = '0, i_f_value = '0;
    logic        i_low_known = 1'b0, i_high_known = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_point_x;
    logic [15:0] o_steps_done;

    regula_falsi_root_finder u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic [63:0] m_target, m_tol;
    logic [15:0] m_maxit;
    logic [63:0] lo_pt, lo_res, hi_pt, hi_res, trial, wtarget, prev_win, prev_res;
    logic        rising, falling, bisect, hi_pending;
    logic [15:0] iters;
    t_phase      phase;
    logic [63:0] last_point;

    t_req        pending_reqs[$];
    t_answer     expected_answers[$];
    int          errors = 0;
    int          sender_idle = 31, receiver_idle = 79;
    longint      cycles = 0;
    bit          in_taken = 1'b0;

    function automatic bit slt(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [63:0] adiff(logic [63:0] a, logic [63:0] b);
        return slt(a, b) ? b - a : a - b;
    endfunction

    function automatic bit fp_step(output logic [63:0] x);
        logic [127:0] prod, quo;
        logic [63:0]  num, den, mag;
        logic [64:0]  biased;
        bit           down;
        down = slt(lo_res, wtarget) != slt(lo_res, hi_res);
        num = adiff(lo_res, wtarget);
        den = adiff(lo_res, hi_res);
        x = '0;
        if (den == 0) return 1'b0;
        prod = {64'd0, num} * {64'd0, adiff(hi_pt, lo_pt)};
        quo = prod / {64'd0, den};
        mag = (quo[127:64] != 0) ? ALL_ONES : quo[63:0];
        biased = {1'b0, lo_pt ^ SIGN_BIT};
        if (down) biased = (mag > biased[63:0]) ? 65'd0 : biased - mag;
        else begin
            biased = biased + mag;
            if (biased[64]) biased = {1'b0, ALL_ONES};
        end
        x = biased[63:0] ^ SIGN_BIT;
        return 1'b1;
    endfunction

    function automatic t_answer give(t_status s, logic [63:0] x);
        t_answer a;
        a.status = s;
        a.point_x = x;
        a.steps = iters;
        return a;
    endfunction

    function automatic t_answer fail_with(t_status s);
        phase = PH_IDLE;
        return give(s, '0);
    endfunction

    function automatic t_answer begin_search();
        logic [63:0] x;
        rising = slt(lo_res, hi_res);
        falling = slt(hi_res, lo_res);
        if (!fp_step(x)) return fail_with(ST_NOCONV);
        trial = x;
        phase = PH_TRIAL;
        return give(ST_EVAL, x);
    endfunction

    function automatic t_answer trial_value(logic [63:0] f);
        logic [63:0] win, nxt, a, b;
        logic [68:0] w20, p19;
        bit          rslow;
        if (iters > 0 && slt(lo_pt, trial) && slt(trial, hi_pt)
            && adiff(hi_pt, lo_pt) < m_tol)
            wtarget = f;
        if (adiff(f, wtarget) <= m_tol) begin
            phase = PH_IDLE;
            return give(ST_ROOT, trial);
        end
        if (iters >= m_maxit) return fail_with(ST_NOCONV);
        if (slt(trial, lo_pt)) begin
            hi_pt = lo_pt; hi_res = lo_res; lo_pt = trial; lo_res = f;
        end else if (slt(hi_pt, trial)) begin
            lo_pt = hi_pt; lo_res = hi_res; hi_pt = trial; hi_res = f;
        end else if (slt(f, wtarget) == slt(hi_res, wtarget)
                     && f != wtarget && hi_res != wtarget) begin
            hi_pt = trial; hi_res = f;
        end else if (f != wtarget && hi_res != wtarget) begin
            lo_pt = trial; lo_res = f;
        end
        rising = rising || slt(lo_res, hi_res);
        falling = falling || slt(hi_res, lo_res);
        if (rising && falling) return fail_with(ST_NONMONO);
        win = adiff(hi_pt, lo_pt);
        rslow = adiff(f, wtarget) > adiff(prev_res, wtarget) / 5;
        w20 = {5'd0, win} * 69'd20;
        p19 = {5'd0, prev_win} * 69'd19;
        if (rslow && w20 > p19) bisect = 1'b1;
        prev_res = f;
        if (bisect) begin
            a = lo_pt ^ SIGN_BIT;
            b = hi_pt ^ SIGN_BIT;
            nxt = ((a >> 1) + (b >> 1) + {63'd0, a[0] & b[0]}) ^ SIGN_BIT;
        end else if (!fp_step(nxt)) return fail_with(ST_NOCONV);
        prev_win = win;
        iters = iters + 1'b1;
        trial = nxt;
        return give(ST_EVAL, nxt);
    endfunction

    function automatic t_answer predict_answer(t_req r);
        logic [63:0] xl, xh, vl, vh, t;
        bit          kl, kh, tb;
        if (r.command == 1'b0) begin
            xl = r.x_low; xh = r.x_high; vl = r.kv_low; vh = r.kv_high;
            kl = r.low_known; kh = r.high_known;
            if (slt(xh, xl)) begin
                t = xl; xl = xh; xh = t;
                t = vl; vl = vh; vh = t;
                tb = kl; kl = kh; kh = tb;
            end
            lo_pt = xl; hi_pt = xh;
            lo_res = kl ? vl : '0;
            hi_res = kh ? vh : '0;
            wtarget = m_target;
            prev_win = ALL_ONES;
            prev_res = MAX_POS;
            rising = 0; falling = 0; bisect = 0;
            iters = '0;
            trial = '0;
            hi_pending = !kh;
            if (!kl) begin
                phase = PH_LOW;
                return give(ST_EVAL, lo_pt);
            end
            if (!kh) begin
                phase = PH_HIGH;
                return give(ST_EVAL, hi_pt);
            end
            return begin_search();
        end
        case (phase)
            PH_LOW: begin
                lo_res = r.f_value;
                if (hi_pending) begin
                    phase = PH_HIGH;
                    return give(ST_EVAL, hi_pt);
                end
                return begin_search();
            end
            PH_HIGH: begin
                hi_res = r.f_value;
                hi_pending = 0;
                return begin_search();
            end
            PH_TRIAL: return trial_value(r.f_value);
            default: return give(ST_NOCONV, '0);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // hold
            end else if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                i_command <= r.command;
                i_x_low <= r.x_low;
                i_x_high <= r.x_high;
                i_known_low_value <= r.kv_low;
                i_known_high_value <= r.kv_high;
                i_low_known <= r.low_known;
                i_high_known <= r.high_known;
                i_f_value <= r.f_value;
            end else begin
                i_in_valid <= 1'b0;
            end
            i_out_stall <= ($urandom_range(99) < receiver_idle);
        end
    end

    // acceptance of input: predict at the accepting edge
    always @(posedge i_clk) begin
        cycles++;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            t_req r;
            r.command = i_command;
            r.x_low = i_x_low;
            r.x_high = i_x_high;
            r.kv_low = i_known_low_value;
            r.kv_high = i_known_high_value;
            r.low_known = i_low_known;
            r.high_known = i_high_known;
            r.f_value = i_f_value;
            expected_answers.push_back(predict_answer(r));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", {62'd0, o_status}, '0);
            end else begin
                t_answer e;
                e = expected_answers.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", {62'd0, o_status}, {62'd0, e.status});
                if (o_point_x !== e.point_x) report_mismatch("point_x", o_point_x, e.point_x);
                if (o_steps_done !== e.steps)
                    report_mismatch("steps_done", {48'd0, o_steps_done}, {48'd0, e.steps});
                last_point = o_point_x;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 64'd4000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return SIGN_BIT;
            1: return MAX_POS;
            2: return '0;
            3: return rand64();
            default: return {{32{1'b0}}, $urandom} - 64'h8000_0000;
        endcase
    endfunction

    task automatic push_start(logic [63:0] xl, logic [63:0] xh, logic [63:0] vl,
                              logic [63:0] vh, bit kl, bit kh);
        t_req r;
        r.command = 1'b0; r.x_low = xl; r.x_high = xh; r.kv_low = vl; r.kv_high = vh;
        r.low_known = kl; r.high_known = kh; r.f_value = rand64();
        pending_reqs.push_back(r);
    endtask

    task automatic push_value(logic [63:0] f);
        t_req r;
        r.command = 1'b1; r.x_low = rand64(); r.x_high = rand64(); r.kv_low = rand64();
        r.kv_high = rand64(); r.low_known = 1'($urandom); r.high_known = 1'($urandom);
        r.f_value = f;
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET: m_target = val;
            CFG_TOL:    m_tol = {1'b0, val[62:0]};
            default:    m_maxit = val[15:0];
        endcase
    endtask

    // answer f(x): linear slope, random noise; or random, or target; feedback driven
    task automatic run_solves(int n_items);
        int sent;
        int steps;
        logic [63:0] slope, x;
        sent = 0;
        while (sent < n_items) begin
            slope = {32'd0, $urandom} >> $urandom_range(31);
            push_start(pick_value(), pick_value(), pick_value(), pick_value(),
                       1'($urandom), 1'($urandom));
            sent++;
            steps = $urandom_range(30);
            repeat (steps) begin
                while (pending_reqs.size() != 0 || i_in_valid || expected_answers.size() != 0)
                    @(posedge i_clk);
                x = last_point;
                case ($urandom_range(9))
                    0: push_value(rand64());
                    1: push_value(m_target);
                    default: push_value(($signed(x) >>> 16) * $signed(slope)
                                        + {{56{1'b0}}, 8'($urandom)});
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        last_point = '0;
        m_target = '0; m_tol = 64'd4295; m_maxit = 16'd50;
        lo_pt = '0; lo_res = '0; hi_pt = '0; hi_res = '0; trial = '0; wtarget = '0;
        prev_win = ALL_ONES; prev_res = MAX_POS;
        rising = 0; falling = 0; bisect = 0; hi_pending = 0; iters = '0;
        phase = PH_IDLE;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        push_value(64'd5);
        push_start(64'h0000_0001_0000_0000, '0, '0, '0, 1'b0, 1'b0);
        push_value(SIGN_BIT);
        push_value(MAX_POS);
        push_value(64'd3);
        push_start(SIGN_BIT, MAX_POS, SIGN_BIT, MAX_POS, 1'b1, 1'b1);
        push_value('0);
        push_start(MAX_POS, SIGN_BIT, 64'd7, 64'd7, 1'b1, 1'b1);
        push_start('0, 64'h0000_0004_0000_0000, 64'hFFFF_FFFF_0000_0000, '0, 1'b1, 1'b0);
        push_value(64'h0000_0003_0000_0000);
        push_value(64'h0000_0001_0000_0000);
        push_value(ALL_ONES);
        push_start('0, 64'd100, 64'd50, ALL_ONES, 1'b1, 1'b1);
        push_value(64'd10);
        push_value(ALL_ONES);
        push_start(64'd10, 64'd10, 64'd1, 64'd2, 1'b1, 1'b1);
        push_value(64'd5);
        drain();

        write_reg(CFG_MAXIT, 64'd0);
        write_reg(CFG_TOL, '0);
        push_start('0, 64'h0000_0010_0000_0000, SIGN_BIT, MAX_POS, 1'b1, 1'b1);
        push_value(64'd1);
        push_start('0, 64'd16, ALL_ONES, 64'd1, 1'b1, 1'b1);
        push_value('0);
        drain();

        write_reg(CFG_TOL, ALL_ONES);
        write_reg(CFG_MAXIT, 64'hFFFF);
        write_reg(CFG_TARGET, SIGN_BIT);
        run_solves(20);
        drain();

        write_reg(CFG_TARGET, 64'h0000_0000_8000_0000);
        write_reg(CFG_TOL, 64'h0000_0000_0001_0000);
        write_reg(CFG_MAXIT, 64'd40);
        run_solves(630);
        drain();

        sender_idle = 79; receiver_idle = 31;
        write_reg(CFG_TARGET, MAX_POS);
        write_reg(CFG_TOL, 64'd4295);
        write_reg(CFG_MAXIT, 64'd3);
        run_solves(620);
        drain();

        sender_idle = 0; receiver_idle = 0;
        write_reg(CFG_TARGET, '0);
        write_reg(CFG_TOL, 64'd1000);
        write_reg(CFG_MAXIT, 64'd50);
        run_solves(620);
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* regula_falsi_root_finder.f */
sv/rfr_pkg.sv
sv/rfr_div.sv
sv/rfr_datapath.sv
sv/rfr_ctrl.sv
sv/regula_falsi_root_finder.sv
tb/tb_regula_falsi_root_finder.sv
